// ===== hdl/mmt_pkg.sv =====
package mmt_pkg;

	localparam int VALUES      = 1024;
	localparam int BLOCK       = 32;
	localparam int COUNT_BITS  = 16;

	localparam int NBLOCKS     = (VALUES + BLOCK - 1) / BLOCK;
	localparam int VAL_W       = $clog2(VALUES);
	localparam int OFF_W       = $clog2(BLOCK);
	localparam int BLK_W       = VAL_W - OFF_W;
	localparam int IN_W        = 12;
	localparam int LIMIT_W     = 11;
	localparam int FIFO_DEPTH  = 2;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic [LIMIT_W-1:0]    LIMIT_RESET = LIMIT_W'(1024);
	localparam logic [LIMIT_W-1:0]    LIMIT_VALUES = LIMIT_W'(VALUES);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic MODE_ADD    = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef struct packed {
		logic             mode;
		logic             oor;
		logic [VAL_W-1:0] idx;
	} item_t;

endpackage

// ===== hdl/mmt_ram.sv =====
module mmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/mmt_front.sv =====
module mmt_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          mode,
	input  logic [mmt_pkg::IN_W-1:0]      value,
	input  logic                          cfg_we,
	input  logic [mmt_pkg::LIMIT_W-1:0]   cfg_wdata,
	output logic [mmt_pkg::LIMIT_W-1:0]   eff_limit,
	output logic                          q_valid,
	output mmt_pkg::item_t                q_item,
	input  logic                          q_take
);
	import mmt_pkg::*;

	logic [LIMIT_W-1:0]    limit_q;
	item_t                 fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_push;
	logic                  do_pop;
	item_t                 item_new;

	assign eff_limit = (limit_q > LIMIT_VALUES) ? LIMIT_VALUES : limit_q;

	always_comb begin
		item_new.mode = mode;
		item_new.oor  = (value >= {1'b0, eff_limit});
		item_new.idx  = value[VAL_W-1:0];
	end

	assign full    = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item  = fifo_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_take && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= item_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("queue count not reduced on transfer out");

	a_oor_limit: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |-> (item_new.oor == (value >= {1'b0, eff_limit})))
		else $error("range class mismatch");

endmodule

// ===== hdl/mmt_back.sv =====
module mmt_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  mmt_pkg::item_t              q_item,
	output logic                        q_take,
	input  logic [mmt_pkg::LIMIT_W-1:0] eff_limit,
	output logic                        empty,
	input  logic                        pop,
	output logic [mmt_pkg::LIMIT_W-1:0] mex,
	output logic                        out_of_range,
	output logic                        remove_absent
);
	import mmt_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_UPD  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIND = 2'd3;

	logic [1:0]            state_q;
	item_t                 item_q;
	logic                  absent_q;
	logic [BLK_W-1:0]      blk_q;
	logic                  all_full_q;
	logic [NBLOCKS-1:0]    full_q;
	logic [NBLOCKS-1:0]    row_valid_q;
	logic                  out_valid_q;
	logic [LIMIT_W-1:0]    mex_q;
	logic                  oor_q;
	logic                  absent_out_q;

	logic                  cnt_re;
	logic                  cnt_we;
	logic [COUNT_BITS-1:0] cnt_rd;
	logic [COUNT_BITS-1:0] cnt_cur;
	logic [COUNT_BITS-1:0] cnt_new;
	logic                  map_re;
	logic                  map_we;
	logic [BLK_W-1:0]      map_raddr;
	logic [BLOCK-1:0]      map_rd;
	logic [BLOCK-1:0]      row_cur;
	logic [BLOCK-1:0]      row_new;
	logic [BLK_W-1:0]      upd_row;
	logic [OFF_W-1:0]      upd_off;
	logic                  present;
	logic                  present_new;
	logic                  absent_now;
	logic [BLK_W-1:0]      blk_first;
	logic [BLOCK-1:0]      scan_row;
	logic [OFF_W-1:0]      zero_off;
	logic [LIMIT_W-1:0]    found;
	logic [LIMIT_W-1:0]    mex_new;
	logic                  out_free;

	assign upd_row = item_q.idx[VAL_W-1:OFF_W];
	assign upd_off = item_q.idx[OFF_W-1:0];

	mmt_ram #(.WIDTH(COUNT_BITS), .DEPTH(VALUES)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (item_q.idx),
		.wdata (cnt_new),
		.re    (cnt_re),
		.raddr (q_item.idx),
		.rdata (cnt_rd)
	);

	mmt_ram #(.WIDTH(BLOCK), .DEPTH(NBLOCKS)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (upd_row),
		.wdata (row_new),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rd)
	);

	assign q_take   = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || pop;

	// update of one count and its presence bit
	always_comb begin
		row_cur     = row_valid_q[upd_row] ? map_rd : '0;
		present     = row_cur[upd_off];
		cnt_cur     = present ? cnt_rd : '0;
		cnt_new     = cnt_cur;
		present_new = present;
		absent_now  = 1'b0;
		if (item_q.mode == MODE_ADD) begin
			if (cnt_cur != COUNT_MAX) begin
				cnt_new = cnt_cur + 1'b1;
			end
			present_new = 1'b1;
		end else if (!present) begin
			absent_now = 1'b1;
		end else begin
			cnt_new     = cnt_cur - 1'b1;
			present_new = (cnt_new != '0);
		end
		row_new          = row_cur;
		row_new[upd_off] = present_new;
	end

	assign cnt_we = (state_q == ST_UPD) && !absent_now;
	assign map_we = cnt_we;
	assign cnt_re = (state_q == ST_IDLE) && q_valid && !q_item.oor;

	// first block that is not full
	always_comb begin
		blk_first = '0;
		for (int b = NBLOCKS - 1; b >= 0; b--) begin
			if (!full_q[b]) begin
				blk_first = BLK_W'(b);
			end
		end
	end

	always_comb begin
		map_re    = 1'b0;
		map_raddr = blk_first;
		if (state_q == ST_IDLE) begin
			map_re    = q_valid && !q_item.oor;
			map_raddr = q_item.idx[VAL_W-1:OFF_W];
		end else if (state_q == ST_SCAN) begin
			map_re = 1'b1;
		end
	end

	// first absent value in the chosen block
	always_comb begin
		scan_row = row_valid_q[blk_q] ? map_rd : '0;
		zero_off = '0;
		for (int i = BLOCK - 1; i >= 0; i--) begin
			if (!scan_row[i]) begin
				zero_off = OFF_W'(i);
			end
		end
		found   = all_full_q ? LIMIT_VALUES : LIMIT_W'({blk_q, zero_off});
		mex_new = (found < eff_limit) ? found : eff_limit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			full_q      <= '0;
			row_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= q_item.oor ? ST_SCAN : ST_UPD;
					end
				end
				ST_UPD: begin
					if (map_we) begin
						row_valid_q[upd_row] <= 1'b1;
						full_q[upd_row]      <= &row_new;
					end
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					state_q <= ST_FIND;
				end
				ST_FIND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_FIND && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			item_q   <= q_item;
			absent_q <= 1'b0;
		end
		if (state_q == ST_UPD) begin
			absent_q <= absent_now;
		end
		if (state_q == ST_SCAN) begin
			blk_q      <= blk_first;
			all_full_q <= &full_q;
		end
		if (state_q == ST_FIND && out_free) begin
			mex_q        <= mex_new;
			oor_q        <= item_q.oor;
			absent_out_q <= absent_q;
		end
	end

	assign empty         = !out_valid_q;
	assign mex           = mex_q;
	assign out_of_range  = oor_q;
	assign remove_absent = absent_out_q;

	a_full_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q & ~row_valid_q) == '0)
		else $error("full block without written row");

	a_mex_cap: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (mex <= eff_limit))
		else $error("mex above limit");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(out_of_range && remove_absent))
		else $error("both flags set");

	a_find_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIND && out_free) |=> (state_q == ST_IDLE && out_valid_q))
		else $error("result not delivered from search");

endmodule

// ===== hdl/multiset_mex_tracker_unit.sv =====
// Multiset mex tracker.
// Input channel: push/full with fields mode (0 add, 1 remove) and value.
// An item transfers at a clock edge with push high and full low.
// Result channel: empty/pop with fields mex, out_of_range, remove_absent.
// The oldest result is shown while empty is low and transfers on pop.
// Configuration: cfg_we writes cfg_wdata into value_limit at the clock edge;
// write only while no item is in flight.
// The back end takes the next item only once the last result is registered;
// each item passes count read, read-modify-write, block search and bitmap
// search over the count memory and the presence bitmap memory, and an
// out-of-range item skips the count read and the read-modify-write.
// A two-entry input queue lets the front keep taking items while the back
// end works. When the receiver stalls, the back end holds its finished
// result in the search stage, the input queue fills and full rises.
// Reset: the multiset is empty at once (bitmap rows carry valid bits, so no
// clearing pass is needed) and value_limit returns to 1024.
module multiset_mex_tracker_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        mode,
	input  logic [mmt_pkg::IN_W-1:0]    value,
	output logic                        empty,
	input  logic                        pop,
	output logic [mmt_pkg::LIMIT_W-1:0] mex,
	output logic                        out_of_range,
	output logic                        remove_absent,
	input  logic                        cfg_we,
	input  logic [mmt_pkg::LIMIT_W-1:0] cfg_wdata
);
	import mmt_pkg::*;

	logic               q_valid;
	logic               q_take;
	item_t              q_item;
	logic [LIMIT_W-1:0] eff_limit;

	mmt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.eff_limit (eff_limit),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_take    (q_take)
	);

	mmt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_take        (q_take),
		.eff_limit     (eff_limit),
		.empty         (empty),
		.pop           (pop),
		.mex           (mex),
		.out_of_range  (out_of_range),
		.remove_absent (remove_absent)
	);

endmodule
